FILE: hdl/srtc_pkg.sv
// ----------------------------------------------------------------------------
// srtc_pkg
// Shared types and constants for the speed ramp and throttle command core.
// ----------------------------------------------------------------------------
package srtc_pkg;

    // Event codes carried in the kind field of an input beat
    typedef enum logic [1:0] {
        KIND_COMMAND   = 2'd0,
        KIND_MEASURED  = 2'd1,
        KIND_TICK      = 2'd2,
        KIND_EMERGENCY = 2'd3
    } t_kind;

    // Configuration register indexes
    localparam logic [1:0] CFG_RAMP_UP   = 2'd0;
    localparam logic [1:0] CFG_RAMP_DOWN = 2'd1;
    localparam logic [1:0] CFG_DEADBAND  = 2'd2;
    localparam logic [1:0] CFG_CEILING   = 2'd3;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 12;

    // Reset values of the configuration registers
    localparam logic [11:0] RAMP_UP_RST   = 12'd410;
    localparam logic [11:0] RAMP_DOWN_RST = 12'd401;
    localparam logic [9:0]  DEADBAND_RST  = 10'd20;
    localparam logic [10:0] CEILING_RST   = 11'd563;

    // Throttle map constants
    localparam logic signed [11:0] HOLD_THROTTLE = 12'sd26;
    localparam logic signed [11:0] FULL_BRAKE    = -12'sd1024;
    localparam logic signed [17:0] BRAKE_LIMIT   = 18'sd51;

    // Input beat
    typedef struct packed {
        t_kind              kind;
        logic signed [15:0] target_speed;
        logic signed [15:0] speed_value;
        logic signed [15:0] steering_angle;
        logic               stop_request;
    } t_in_beat;

    // Result beat
    typedef struct packed {
        logic signed [15:0] command_speed;
        logic signed [11:0] throttle;
        logic signed [15:0] steering_out;
    } t_out_beat;

endpackage

FILE: hdl/srtc_in_if.sv
// ----------------------------------------------------------------------------
// srtc_in_if
// Valid/ready channel carrying input event beats.
// ----------------------------------------------------------------------------
interface srtc_in_if;
    logic               valid;
    logic               ready;
    srtc_pkg::t_in_beat data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/srtc_out_if.sv
// ----------------------------------------------------------------------------
// srtc_out_if
// Valid/ready channel carrying result beats.
// ----------------------------------------------------------------------------
interface srtc_out_if;
    logic                valid;
    logic                ready;
    srtc_pkg::t_out_beat data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/speed_ramp_throttle_command_core.sv
// ----------------------------------------------------------------------------
// speed_ramp_throttle_command_core
// Slew-rate limited speed command with a deadband throttle map.
// ----------------------------------------------------------------------------
// Takes one event beat per clock (command, measured speed, tick, emergency).
// Each beat lands in an input register; as it leaves that register it updates
// the speed state and, for a tick once a command has been seen, loads one
// result beat into the output register. Sustained rate is one beat per cycle;
// the input stalls only while a tick is waiting behind a result beat that the
// sink has not taken. Config writes go straight to the registers and are meant
// to happen while the core is idle.
// ----------------------------------------------------------------------------
module speed_ramp_throttle_command_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [srtc_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [srtc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    srtc_in_if.sink                             i_in,
    srtc_out_if.source                          o_out
);
    import srtc_pkg::*;

    // Config registers
    logic [11:0] r_up_step;
    logic [11:0] r_down_step;
    logic [9:0]  r_deadband;
    logic [10:0] r_ceiling;

    // Speed state
    logic signed [15:0] r_ramped;
    logic signed [15:0] r_goal;
    logic signed [15:0] r_measured;
    logic signed [15:0] r_steering;
    logic               r_ready;
    logic               r_emerg;

    // Pipeline registers
    logic      r_in_valid;
    t_in_beat  r_in;
    logic      r_out_valid;
    t_out_beat r_out;

    logic signed [15:0] n_ramped;
    logic signed [15:0] n_goal;
    logic signed [11:0] n_throttle;

    logic accept;
    logic emit;
    logic out_free;
    logic advance;

    // Handshake: a tick that emits waits for a free output slot
    assign emit     = r_in_valid && (r_in.kind == KIND_TICK) && r_ready;
    assign out_free = !r_out_valid || o_out.ready;
    assign advance  = r_in_valid && (!emit || out_free);
    assign i_in.ready = !r_in_valid || advance;
    assign accept   = i_in.valid && i_in.ready;

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // Config write port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_up_step   <= RAMP_UP_RST;
            r_down_step <= RAMP_DOWN_RST;
            r_deadband  <= DEADBAND_RST;
            r_ceiling   <= CEILING_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_RAMP_UP:   r_up_step   <= i_cfg_data;
                CFG_RAMP_DOWN: r_down_step <= i_cfg_data;
                CFG_DEADBAND:  r_deadband  <= i_cfg_data[9:0];
                CFG_CEILING:   r_ceiling   <= i_cfg_data[10:0];
                default: ;
            endcase
        end
    end

    // Goal from a command: negative or zero targets clamp to zero
    always_comb begin
        if (r_in.target_speed <= 16'sd0) begin
            n_goal = '0;
        end else begin
            n_goal = r_in.target_speed;
        end
    end

    // Ramp toward the goal with asymmetric steps, saturated to 16 bits
    logic signed [17:0] ramp_hi;
    logic signed [17:0] ramp_lo;
    logic signed [17:0] goal_x;
    assign ramp_hi = 18'(r_ramped) + signed'({6'd0, r_up_step});
    assign ramp_lo = 18'(r_ramped) - signed'({6'd0, r_down_step});
    assign goal_x  = 18'(r_goal);

    always_comb begin
        if (goal_x > ramp_hi) begin
            n_ramped = (ramp_hi > 18'sd32767) ? 16'sh7fff : ramp_hi[15:0];
        end else if (goal_x < ramp_lo) begin
            n_ramped = (ramp_lo < -18'sd32768) ? 16'sh8000 : ramp_lo[15:0];
        end else begin
            n_ramped = r_goal;
        end
    end

    // Throttle map on the error goal - measured
    logic signed [17:0] err;
    logic signed [17:0] dband;
    logic signed [17:0] over;
    logic signed [19:0] brake;
    assign err   = 18'(r_goal) - 18'(r_measured);
    assign dband = signed'({8'd0, r_deadband});
    assign over  = err - dband;
    assign brake = 20'(err) + (20'(err) <<< 1);

    always_comb begin
        if (r_emerg) begin
            n_throttle = FULL_BRAKE;
        end else if (err < dband && err > -dband) begin
            n_throttle = HOLD_THROTTLE;
        end else if (err >= dband) begin
            if (over > signed'({7'd0, r_ceiling})) begin
                n_throttle = ({1'b0, r_ceiling} < 12'(HOLD_THROTTLE))
                           ? HOLD_THROTTLE : signed'({1'b0, r_ceiling});
            end else if (over < 18'(HOLD_THROTTLE)) begin
                n_throttle = HOLD_THROTTLE;
            end else begin
                n_throttle = over[11:0];
            end
        end else if (err < -BRAKE_LIMIT) begin
            n_throttle = '0;
        end else if (brake < 20'(FULL_BRAKE)) begin
            n_throttle = FULL_BRAKE;
        end else begin
            n_throttle = brake[11:0];
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
        if (accept) begin
            r_in <= i_in.data;
        end
    end

    // State update as each beat leaves the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ramped   <= '0;
            r_goal     <= '0;
            r_measured <= '0;
            r_steering <= '0;
            r_ready    <= 1'b0;
            r_emerg    <= 1'b0;
        end else if (advance) begin
            unique case (r_in.kind)
                KIND_COMMAND: begin
                    if (r_in.stop_request) begin
                        r_ramped   <= '0;
                        r_goal     <= '0;
                        r_steering <= '0;
                    end else begin
                        r_goal     <= n_goal;
                        r_ramped   <= r_in.speed_value;
                        r_measured <= r_in.speed_value;
                        r_steering <= r_in.steering_angle;
                        r_ready    <= 1'b1;
                    end
                end
                KIND_MEASURED:  r_measured <= r_in.speed_value;
                KIND_TICK: begin
                    if (r_ready) begin
                        r_ramped <= n_ramped;
                    end
                end
                KIND_EMERGENCY: r_emerg <= 1'b1;
                default: ;
            endcase
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
        if (advance && emit) begin
            r_out.command_speed <= r_emerg ? '0 : n_ramped;
            r_out.throttle      <= n_throttle;
            r_out.steering_out  <= r_steering;
        end
    end

`ifndef SYNTHESIS
    // Emergency stays latched until reset
    a_emerg_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_emerg |=> r_emerg)
        else $error("emergency latch dropped");

    // Ready stays set once a command has been taken
    a_ready_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ready |=> r_ready)
        else $error("ready flag dropped");

    // Goal speed is never negative
    a_goal_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_goal[15])
        else $error("negative goal speed");

    // A new result is loaded only when the output slot is free
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |=> r_out_valid && $stable(r_out))
        else $error("result overwritten while stalled");
`endif

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the speed ramp and throttle command core.
// ----------------------------------------------------------------------------
// Drives event beats (commands, measured speeds, ticks, emergency stops)
// through the input channel with random gaps while the result channel
// back-pressures at random. A scoreboard tracks the ramp state, predicts the
// beat each tick should produce and compares every result field by field.
// The run steps through several register settings, extremes included, and
// latches the emergency stop only in its last phase.
// ----------------------------------------------------------------------------

// Ramp state tracker and store of expected command beats
class ramp_scoreboard;
    localparam int BRAKE_GAIN = 3;
    localparam int SPEED_MAX  = 32767;
    localparam int SPEED_MIN  = -32768;

    int up_step;
    int down_step;
    int band;
    int ceiling;

    int ramped;
    int goal;
    int measured;
    int steer;
    bit armed;
    bit estop;

    srtc_pkg::t_out_beat expected_cmds[$];
    int errors;

    function new();
        up_step   = srtc_pkg::RAMP_UP_RST;
        down_step = srtc_pkg::RAMP_DOWN_RST;
        band      = srtc_pkg::DEADBAND_RST;
        ceiling   = srtc_pkg::CEILING_RST;
    endfunction

    function void set_register(logic [1:0] index, logic [11:0] value);
        case (index)
            srtc_pkg::CFG_RAMP_UP:   up_step   = value;
            srtc_pkg::CFG_RAMP_DOWN: down_step = value;
            srtc_pkg::CFG_DEADBAND:  band      = value[9:0];
            srtc_pkg::CFG_CEILING:   ceiling   = value[10:0];
            default: ;
        endcase
    endfunction

    function int pending();
        return expected_cmds.size();
    endfunction

    // Deadband throttle map on the error goal - measured
    function logic signed [11:0] throttle_now();
        int err;
        int t;
        err = goal - measured;
        t = srtc_pkg::HOLD_THROTTLE;
        if (estop) begin
            t = srtc_pkg::FULL_BRAKE;
        end else if (err >= band) begin
            t = err - band;
            if (t > ceiling) t = ceiling;
            if (t < srtc_pkg::HOLD_THROTTLE) t = srtc_pkg::HOLD_THROTTLE;
        end else if (err <= -band) begin
            if (err < -srtc_pkg::BRAKE_LIMIT) begin
                t = 0;
            end else begin
                t = err * BRAKE_GAIN;
                if (t < srtc_pkg::FULL_BRAKE) t = srtc_pkg::FULL_BRAKE;
            end
        end
        return 12'(t);
    endfunction

    // Update state for one accepted event beat; ticks queue a command beat
    function void note_event(srtc_pkg::t_in_beat ev);
        srtc_pkg::t_out_beat cmd;
        case (ev.kind)
            srtc_pkg::KIND_COMMAND: begin
                if (ev.stop_request) begin
                    ramped = 0;
                    goal   = 0;
                    steer  = 0;
                end else begin
                    goal     = (ev.target_speed > 0) ? int'(ev.target_speed) : 0;
                    ramped   = ev.speed_value;
                    measured = ev.speed_value;
                    steer    = ev.steering_angle;
                    armed    = 1'b1;
                end
            end
            srtc_pkg::KIND_MEASURED:  measured = ev.speed_value;
            srtc_pkg::KIND_EMERGENCY: estop = 1'b1;
            default: begin
                if (armed) begin
                    // one slew step toward the goal, asymmetric up/down
                    if (goal > ramped + up_step) ramped = ramped + up_step;
                    else if (goal < ramped - down_step) ramped = ramped - down_step;
                    else ramped = goal;
                    if (ramped > SPEED_MAX) ramped = SPEED_MAX;
                    else if (ramped < SPEED_MIN) ramped = SPEED_MIN;
                    cmd.command_speed = estop ? 16'sd0 : 16'(ramped);
                    cmd.throttle      = throttle_now();
                    cmd.steering_out  = 16'(steer);
                    expected_cmds.push_back(cmd);
                end
            end
        endcase
    endfunction

    // Compare one result beat with the oldest expected command
    function void check_cmd(srtc_pkg::t_out_beat got);
        srtc_pkg::t_out_beat want;
        if (expected_cmds.size() == 0) begin
            $error("result beat with nothing expected: speed %0d throttle %0d steer %0d",
                   got.command_speed, got.throttle, got.steering_out);
            errors++;
            return;
        end
        want = expected_cmds.pop_front();
        if (got.command_speed !== want.command_speed) begin
            $error("command_speed: expected %0d, got %0d",
                   want.command_speed, got.command_speed);
            errors++;
        end
        if (got.throttle !== want.throttle) begin
            $error("throttle: expected %0d, got %0d", want.throttle, got.throttle);
            errors++;
        end
        if (got.steering_out !== want.steering_out) begin
            $error("steering_out: expected %0d, got %0d",
                   want.steering_out, got.steering_out);
            errors++;
        end
    endfunction
endclass

module tb;
    import srtc_pkg::*;

    localparam int SETTLE_CYCLES = 4;
    localparam int PHASE_EVENTS  = 150;
    localparam int PHASES        = 6;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;
    bit                     no_idle = 1'b0;

    srtc_in_if  in_ch();
    srtc_out_if out_ch();

    ramp_scoreboard board = new();

    speed_ramp_throttle_command_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watch both channels; input beats are noted before results are checked
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) board.note_event(in_ch.data);
            if (out_ch.valid && out_ch.ready) board.check_cmd(out_ch.data);
        end
    end

    // Result sink: random stall bursts
    initial begin
        int stall_left;
        stall_left = 0;
        out_ch.ready = 1'b1;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) stall_left--;
            else if (!no_idle && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 7);
            out_ch.ready <= (stall_left == 0);
        end
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic t_in_beat make_beat(input t_kind kind, input int target,
                                           input int speed, input int steer,
                                           input bit stop);
        t_in_beat b;
        b.kind           = kind;
        b.target_speed   = 16'(target);
        b.speed_value    = 16'(speed);
        b.steering_angle = 16'(steer);
        b.stop_request   = stop;
        return b;
    endfunction

    function automatic logic signed [15:0] random_speed();
        case ($urandom_range(0, 3))
            0: return 16'($urandom);
            1: return 16'(int'($urandom_range(0, 4096)) - 1024);
            2: begin
                case ($urandom_range(0, 4))
                    0: return 16'sh7fff;
                    1: return 16'sh8000;
                    2: return 16'sd0;
                    3: return -16'sd1;
                    default: return 16'sd1;
                endcase
            end
            default: return 16'(int'($urandom_range(0, 24000)) - 4000);
        endcase
    endfunction

    // Speed within +/- spread of center, clipped to 16 bits
    function automatic logic signed [15:0] near_speed(input int center, input int spread);
        int v;
        v = center + int'($urandom_range(0, 2 * spread)) - spread;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return 16'(v);
    endfunction

    // Mostly ticks, with commands and measured speeds aimed around the band
    function automatic t_in_beat random_event(input bit allow_estop);
        t_in_beat b;
        int pick;
        pick             = $urandom_range(0, 99);
        b.target_speed   = random_speed();
        b.speed_value    = random_speed();
        b.steering_angle = 16'(int'($urandom_range(0, 32768)) - 16384);
        b.stop_request   = 1'($urandom_range(0, 1));
        if (pick < 14) begin
            b.kind         = KIND_COMMAND;
            b.stop_request = ($urandom_range(0, 7) == 0);
            if ($urandom_range(0, 2) == 0 && b.target_speed > 0)
                b.speed_value = near_speed(b.target_speed, board.band + 60);
        end else if (pick < 30) begin
            b.kind = KIND_MEASURED;
            if ($urandom_range(0, 1)) b.speed_value = near_speed(board.goal, board.band + 60);
        end else if (allow_estop && pick == 99) begin
            b.kind = KIND_EMERGENCY;
        end else begin
            b.kind = KIND_TICK;
        end
        return b;
    endfunction

    // Present one beat, optionally after an idle burst, and wait for acceptance
    task automatic send_event(input t_in_beat ev);
        if (!no_idle && $urandom_range(0, 4) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= ev;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    // Hold off the input until every expected beat is out, then let the core settle
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (board.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_beat(input logic [CFG_INDEX_W-1:0] index, input logic [11:0] value);
        i_cfg_index <= index;
        i_cfg_data  <= value;
        board.set_register(index, value);
        @(posedge i_clk);
    endtask

    task automatic program_limits(input logic [11:0] up, input logic [11:0] down,
                                  input logic [11:0] band, input logic [11:0] ceil);
        i_cfg_we <= 1'b1;
        cfg_beat(CFG_RAMP_UP, up);
        cfg_beat(CFG_RAMP_DOWN, down);
        cfg_beat(CFG_DEADBAND, band);
        cfg_beat(CFG_CEILING, ceil);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        t_in_beat ev;
        bit       last;
        in_ch.valid = 1'b0;
        in_ch.data  = '0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset register values
        send_event(make_beat(KIND_TICK, 500, 300, 100, 1'b0));          // no result yet
        send_event(make_beat(KIND_MEASURED, 32767, -32768, 16384, 1'b1));
        send_event(make_beat(KIND_COMMAND, -32768, 32767, -16384, 1'b0)); // goal clamps to 0
        send_event(make_beat(KIND_TICK, 0, 0, 0, 1'b0));                // ramp down, past brake limit
        send_event(make_beat(KIND_COMMAND, 32767, -32768, 16384, 1'b0));
        send_event(make_beat(KIND_TICK, 0, 0, 0, 1'b0));                // ramp up, ceiling
        send_event(make_beat(KIND_MEASURED, 0, 32757, 0, 1'b0));        // inside band
        send_event(make_beat(KIND_TICK, 0, 0, 0, 1'b0));
        send_event(make_beat(KIND_COMMAND, 1000, 1030, -1, 1'b0));      // brake slope
        send_event(make_beat(KIND_TICK, 0, 0, 0, 1'b1));
        send_event(make_beat(KIND_MEASURED, 0, 1051, 0, 1'b0));         // edge of brake slope
        send_event(make_beat(KIND_TICK, 0, 0, 0, 1'b0));
        send_event(make_beat(KIND_MEASURED, 0, 1052, 0, 1'b0));         // past brake limit
        send_event(make_beat(KIND_TICK, 0, 0, 0, 1'b0));
        send_event(make_beat(KIND_MEASURED, 0, 980, 0, 1'b0));          // error equals band
        send_event(make_beat(KIND_TICK, 0, 0, 0, 1'b0));
        send_event(make_beat(KIND_MEASURED, 0, 900, 0, 1'b0));
        send_event(make_beat(KIND_TICK, 0, 0, 0, 1'b0));
        send_event(make_beat(KIND_COMMAND, 12345, -1, 777, 1'b1));      // stop command
        send_event(make_beat(KIND_TICK, 0, 0, 0, 1'b0));
        send_event(make_beat(KIND_COMMAND, 0, 0, 0, 1'b0));
        send_event(make_beat(KIND_TICK, 0, 0, 0, 1'b0));
        send_event(make_beat(KIND_COMMAND, 1, -1, 16384, 1'b0));
        send_event(make_beat(KIND_TICK, 0, 0, 0, 1'b0));

        // Random phases, one register setting each; emergency only in the last
        for (int phase = 0; phase < PHASES; phase++) begin
            last = (phase == PHASES - 1);
            wait_drained();
            case (phase)
                0: program_limits(12'd4095, 12'd4095, 12'd1023, 12'd1024);
                1: program_limits(12'd0, 12'd0, 12'd0, 12'd0);
                2: program_limits(12'd1, 12'd1, 12'd0, 12'd10);      // ceiling below hold
                3, 4: program_limits(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                                     12'($urandom_range(0, 1023)), 12'($urandom_range(0, 1024)));
                default: program_limits(RAMP_UP_RST, RAMP_DOWN_RST, 12'(DEADBAND_RST),
                                        12'(CEILING_RST));
            endcase
            for (int n = 0; n < PHASE_EVENTS; n++) begin
                if (last && n >= PHASE_EVENTS / 2) no_idle = 1'b1;
                if (!last && $urandom_range(0, 99) == 0) wait_drained();
                ev = random_event(last && n >= PHASE_EVENTS / 3);
                if (last && n == PHASE_EVENTS * 3 / 4) ev.kind = KIND_EMERGENCY;
                send_event(ev);
            end
        end

        wait_drained();
        if (board.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

FILE: filelist.f
hdl/srtc_pkg.sv
hdl/srtc_in_if.sv
hdl/srtc_out_if.sv
hdl/speed_ramp_throttle_command_core.sv
tb/tb.sv
